// ----- sv/tpjq_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and types of the timed priority job queue.
package tpjq_pkg;

   localparam int NUM_JOBS = 16;
   localparam int SLOT_W   = (NUM_JOBS > 1) ? $clog2(NUM_JOBS) : 1;
   localparam int ID_W     = 4;
   localparam int ID_EXT_W = 9;
   localparam int PRIO_W   = 9;
   localparam int TAG_W    = 32;
   localparam int DELAY_W  = 32;
   localparam int NOW_W    = 63;
   localparam int TIME_W   = 64;
   localparam int ORDER_W  = 16;
   localparam int MOVED_W  = 5;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;

   localparam logic [MODE_W-1:0] MODE_NOW      = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LATER    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TICK     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_DISPATCH = 2'd3;

   localparam logic [STATUS_W-1:0] ST_ACCEPTED   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BUSY       = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DISPATCHED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd3;

   typedef struct packed {
      logic                     is_tick;
      logic                     active;
      logic [TIME_W-1:0]        deadline;
      logic signed [PRIO_W-1:0] prio;
      logic [ORDER_W-1:0]       order;
      logic [ORDER_W-1:0]       counter;
      logic [TIME_W-1:0]        now;
      logic                     found;
      logic [TIME_W-1:0]        best_key;
      logic [ORDER_W-1:0]       best_age;
   } cmp_in_type;

   typedef struct packed {
      logic               better;
      logic [TIME_W-1:0]  key;
      logic [ORDER_W-1:0] age;
   } cmp_out_type;

endpackage

// ----- sv/tpjq_cmp.sv -----
`timescale 1ns / 1ps
// Shared compare unit: rates one table entry against the best one so far.
module tpjq_cmp (
   input  tpjq_pkg::cmp_in_type  cmp_in,
   output tpjq_pkg::cmp_out_type cmp_out
);
   import tpjq_pkg::*;

   logic [TIME_W-1:0]  key;
   logic [ORDER_W-1:0] age;
   logic               eligible;

   // map signed priority onto an unsigned key by flipping the sign bit
   assign key = cmp_in.is_tick ? cmp_in.deadline
                : TIME_W'({~cmp_in.prio[PRIO_W-1], cmp_in.prio[PRIO_W-2:0]});
   assign age = cmp_in.counter - cmp_in.order;
   assign eligible = cmp_in.active && (!cmp_in.is_tick || (cmp_in.deadline <= cmp_in.now));

   assign cmp_out.better = eligible && (!cmp_in.found || (key < cmp_in.best_key) ||
                           ((key == cmp_in.best_key) && (age > cmp_in.best_age)));
   assign cmp_out.key = key;
   assign cmp_out.age = age;

endmodule

// ----- sv/timed_priority_job_queue.sv -----
`timescale 1ns / 1ps
// Timed priority job queue: job table, timer set and ready set with a scan sequencer.
//
// Request channel (req_*): one word per operation, chosen by req_mode: schedule now,
// schedule after req_delay_us, time tick carrying req_now_us, or dispatch.
// Response channel (rsp_*): exactly one word per request, in request order.
// Schedule requests finish in the accept cycle; the response word shows in the cycle after.
// Dispatch walks the job table one slot per cycle through a single shared comparator,
// then applies the best slot and registers the result as the response word.
// Tick loads the time, then repeats a full table pass for every expired job it moves,
// plus one last pass that finds no expired job.
// req_stall is high while an operation is being worked and while a finished response
// word waits under rsp_stall; a new request is taken as soon as the output register
// frees up. The response word holds steady while rsp_stall is high.
// Synchronous reset empties both sets, zeroes the time and age counter and drops any
// pending response. Job contents are not cleared; slot status bits guard them.
module timed_priority_job_queue (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [tpjq_pkg::MODE_W-1:0]             req_mode,
   input  logic [tpjq_pkg::ID_W-1:0]               req_item_id,
   input  logic signed [tpjq_pkg::PRIO_W-1:0]      req_priority_req,
   input  logic [tpjq_pkg::TAG_W-1:0]              req_job_tag,
   input  logic [tpjq_pkg::DELAY_W-1:0]            req_delay_us,
   input  logic [tpjq_pkg::NOW_W-1:0]              req_now_us,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [tpjq_pkg::STATUS_W-1:0]           rsp_status,
   output logic [tpjq_pkg::ID_W-1:0]               rsp_out_id,
   output logic [tpjq_pkg::TAG_W-1:0]              rsp_out_tag,
   output logic [tpjq_pkg::MOVED_W-1:0]            rsp_moved_count
);
   import tpjq_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_JOBS - 1);

   logic [1:0]               state_ff, state_in;
   logic                     is_tick_ff, is_tick_in;
   logic [SLOT_W-1:0]        idx_ff, idx_in;
   logic                     found_ff, found_in;
   logic [SLOT_W-1:0]        best_ff, best_in;
   logic [TIME_W-1:0]        best_key_ff, best_key_in;
   logic [ORDER_W-1:0]       best_age_ff, best_age_in;
   logic [MOVED_W-1:0]       moved_ff, moved_in;
   logic [TIME_W-1:0]        time_ff, time_in;
   logic [ORDER_W-1:0]       counter_ff, counter_in;
   logic [NUM_JOBS-1:0]      queued_ff, queued_in;
   logic [NUM_JOBS-1:0]      waiting_ff, waiting_in;

   logic [STATUS_W-1:0]      res_status_ff, res_status_in;
   logic [ID_W-1:0]          res_id_ff, res_id_in;
   logic [TAG_W-1:0]         res_tag_ff, res_tag_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]          rsp_id_ff, rsp_id_in;
   logic [TAG_W-1:0]         rsp_tag_ff, rsp_tag_in;
   logic [MOVED_W-1:0]       rsp_moved_ff, rsp_moved_in;

   logic signed [PRIO_W-1:0] prio_ff     [NUM_JOBS];
   logic [TIME_W-1:0]        deadline_ff [NUM_JOBS];
   logic [ORDER_W-1:0]       order_ff    [NUM_JOBS];
   logic [TAG_W-1:0]         tag_ff      [NUM_JOBS];

   logic                     out_free;
   logic                     req_accept;
   logic [ID_EXT_W-1:0]      id_ext;
   logic                     id_ok;
   logic [SLOT_W-1:0]        slot;
   logic                     job_wr;
   logic                     deadline_wr;
   logic                     order_wr;
   logic [SLOT_W-1:0]        order_slot;
   cmp_in_type               cmp_in;
   cmp_out_type              cmp_out;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;
   assign id_ext     = ID_EXT_W'(req_item_id);
   assign id_ok      = id_ext < ID_EXT_W'(NUM_JOBS);
   assign slot       = id_ext[SLOT_W-1:0];

   assign cmp_in.is_tick  = is_tick_ff;
   assign cmp_in.active   = is_tick_ff ? waiting_ff[idx_ff] : queued_ff[idx_ff];
   assign cmp_in.deadline = deadline_ff[idx_ff];
   assign cmp_in.prio     = prio_ff[idx_ff];
   assign cmp_in.order    = order_ff[idx_ff];
   assign cmp_in.counter  = counter_ff;
   assign cmp_in.now      = time_ff;
   assign cmp_in.found    = found_ff;
   assign cmp_in.best_key = best_key_ff;
   assign cmp_in.best_age = best_age_ff;

   tpjq_cmp u_cmp (
      .cmp_in  (cmp_in),
      .cmp_out (cmp_out)
   );

   always_comb begin
      state_in      = state_ff;
      is_tick_in    = is_tick_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      best_key_in   = best_key_ff;
      best_age_in   = best_age_ff;
      moved_in      = moved_ff;
      time_in       = time_ff;
      counter_in    = counter_ff;
      queued_in     = queued_ff;
      waiting_in    = waiting_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_tag_in    = res_tag_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_moved_in  = rsp_moved_ff;
      job_wr        = 1'b0;
      deadline_wr   = 1'b0;
      order_wr      = 1'b0;
      order_slot    = slot;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               idx_in   = '0;
               found_in = 1'b0;
               moved_in = '0;
               if (req_mode == MODE_NOW || req_mode == MODE_LATER) begin
                  rsp_valid_in = 1'b1;
                  rsp_id_in    = '0;
                  rsp_tag_in   = '0;
                  rsp_moved_in = '0;
                  if (!id_ok || queued_ff[slot] || waiting_ff[slot]) begin
                     rsp_status_in = ST_BUSY;
                  end else begin
                     rsp_status_in = ST_ACCEPTED;
                     job_wr        = 1'b1;
                     order_wr      = 1'b1;
                     counter_in    = counter_ff + 1'b1;
                     if (req_mode == MODE_NOW) begin
                        queued_in[slot] = 1'b1;
                     end else begin
                        deadline_wr      = 1'b1;
                        waiting_in[slot] = 1'b1;
                     end
                  end
               end else if (req_mode == MODE_TICK) begin
                  time_in    = TIME_W'(req_now_us);
                  is_tick_in = 1'b1;
                  state_in   = S_SCAN;
               end else begin
                  is_tick_in = 1'b0;
                  state_in   = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (cmp_out.better) begin
               found_in    = 1'b1;
               best_in     = idx_ff;
               best_key_in = cmp_out.key;
               best_age_in = cmp_out.age;
            end
            if (idx_ff == LAST_SLOT) begin
               state_in = S_APPLY;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_APPLY: begin
            res_id_in  = '0;
            res_tag_in = '0;
            if (is_tick_ff) begin
               if (found_ff) begin
                  waiting_in[best_ff] = 1'b0;
                  queued_in[best_ff]  = 1'b1;
                  order_wr            = 1'b1;
                  order_slot          = best_ff;
                  counter_in          = counter_ff + 1'b1;
                  moved_in            = moved_ff + 1'b1;
                  idx_in              = '0;
                  found_in            = 1'b0;
                  state_in            = S_SCAN;
               end else begin
                  res_status_in = ST_ACCEPTED;
                  state_in      = S_DONE;
               end
            end else begin
               if (found_ff) begin
                  queued_in[best_ff] = 1'b0;
                  res_status_in      = ST_DISPATCHED;
                  res_id_in          = ID_W'(ID_EXT_W'(best_ff));
                  res_tag_in         = tag_ff[best_ff];
               end else begin
                  res_status_in = ST_EMPTY;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_id_in     = res_id_ff;
               rsp_tag_in    = res_tag_ff;
               rsp_moved_in  = moved_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         found_ff     <= 1'b0;
         time_ff      <= '0;
         counter_ff   <= '0;
         queued_ff    <= '0;
         waiting_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         found_ff     <= found_in;
         time_ff      <= time_in;
         counter_ff   <= counter_in;
         queued_ff    <= queued_in;
         waiting_ff   <= waiting_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_tick_ff    <= is_tick_in;
      idx_ff        <= idx_in;
      best_ff       <= best_in;
      best_key_ff   <= best_key_in;
      best_age_ff   <= best_age_in;
      moved_ff      <= moved_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_tag_ff    <= res_tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_moved_ff  <= rsp_moved_in;
   end

   always_ff @(posedge clock) begin
      if (job_wr) begin
         prio_ff[slot] <= req_priority_req;
         tag_ff[slot]  <= req_job_tag;
      end
      if (deadline_wr) begin
         deadline_ff[slot] <= time_ff + TIME_W'(req_delay_us);
      end
      if (order_wr) begin
         order_ff[order_slot] <= counter_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_id      = rsp_id_ff;
   assign rsp_out_tag     = rsp_tag_ff;
   assign rsp_moved_count = rsp_moved_ff;

endmodule

// ----- sv/tpjq_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the timed priority job queue, bound to the top level.
module tpjq_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic [tpjq_pkg::MODE_W-1:0]          req_mode,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [tpjq_pkg::STATUS_W-1:0]        rsp_status,
   input logic [tpjq_pkg::ID_W-1:0]            rsp_out_id,
   input logic [tpjq_pkg::TAG_W-1:0]           rsp_out_tag,
   input logic [tpjq_pkg::MOVED_W-1:0]         rsp_moved_count
);
   import tpjq_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_scan_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_mode == MODE_TICK || req_mode == MODE_DISPATCH)
      |=> req_stall)
      else $error("request taken during a table scan");

   a_no_job_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DISPATCHED |-> rsp_out_id == '0 && rsp_out_tag == '0)
      else $error("job fields set on a non-dispatch word");

   a_moved_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_ACCEPTED |-> rsp_moved_count == '0)
      else $error("moved count set on a non-accepted word");

endmodule

bind timed_priority_job_queue tpjq_checker u_tpjq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_mode        (req_mode),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_out_id      (rsp_out_id),
   .rsp_out_tag     (rsp_out_tag),
   .rsp_moved_count (rsp_moved_count)
);
